>>> src/otr_pkg.sv
// Shared types and constants for the overwriting trace ring.
// Used by the top, the output queue and the testbench; no dependencies.
`timescale 1ns / 1ps

package otr_pkg;

  // Default parameter values
  localparam int CAPACITY_DEF      = 64;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // Fixed field widths of the ports
  localparam int KIND_W = 2;
  localparam int SEQ_W  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int LOST_W = 32;

  // Request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_DUMP = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // Output buffer geometry
  localparam int OBUF_DEPTH = 2;
  localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
  localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] payload;
    logic [CNT_W-1:0]  retained;
    logic [LOST_W-1:0] lost;
    logic              last;
  } result_t;

endpackage

>>> src/overwrite_trace_ring_top.sv
// Overwriting trace ring: keeps the newest CAPACITY events. A push word is taken
// every cycle while the output queue has room and gives one acknowledge word. A
// dump reads the retained entries one by one through the single memory read port
// (registered read, held while the output queue has no room) and emits the
// entries oldest first, the final one marked last; an empty ring dumps as one
// word. Inputs are not taken while a dump runs. No clearing pass after reset.
// Depends on otr_pkg, otr_mem and otr_obuf.
`timescale 1ns / 1ps

module overwrite_trace_ring_top #(
  parameter int CAPACITY      = otr_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = otr_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [otr_pkg::DATA_W-1:0]  in_event_payload,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [otr_pkg::KIND_W-1:0]  out_result_kind,
  output logic [otr_pkg::SEQ_W-1:0]   out_sequence_number,
  output logic [otr_pkg::DATA_W-1:0]  out_payload_out,
  output logic [otr_pkg::CNT_W-1:0]   out_retained_count,
  output logic [otr_pkg::LOST_W-1:0]  out_overwritten_count,
  output logic                        out_last
);
  import otr_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = SEQ_W + PAYLOAD_WIDTH;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic              state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic              full_r, full_nxt;
  logic [LOST_W-1:0] lost_r, lost_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]     remain_r, remain_nxt;
  logic              rd_pending_r, rd_pending_nxt;
  logic              rd_last_r, rd_last_nxt;

  logic              in_acc, pop, rd_issue, mem_wr;
  logic [CW-1:0]     retained, retained_push;
  logic [OBUF_CW:0]  fill_after;
  logic [OBUF_CW-1:0] ob_count;
  logic [MW-1:0]     mem_rdata;
  result_t           ob_wdata, ob_rdata;
  logic              ob_wr;

  assign retained = full_r ? CW'(CAPACITY) : {1'b0, wp_r};
  assign pop      = out_valid && out_ready;
  assign in_ready = (state_r == ST_IDLE) && !rd_pending_r &&
                    ((ob_count != OBUF_CW'(OBUF_DEPTH)) || pop);
  assign in_acc   = in_valid && in_ready;
  assign mem_wr   = in_acc && (in_req_type == REQ_PUSH);

  // occupancy after this edge, counting a read word that lands now
  assign fill_after = (OBUF_CW + 1)'(ob_count) + (OBUF_CW + 1)'(rd_pending_r)
                      - (OBUF_CW + 1)'(pop);
  assign rd_issue   = (state_r == ST_DUMP) &&
                      (fill_after <= (OBUF_CW + 1)'(OBUF_DEPTH - 1));

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    seq_nxt        = seq_r;
    full_nxt       = full_r;
    lost_nxt       = lost_r;
    rd_addr_nxt    = rd_addr_r;
    remain_nxt     = remain_r;
    rd_pending_nxt = rd_issue;
    rd_last_nxt    = rd_last_r;

    if (mem_wr) begin
      seq_nxt = seq_r + SEQ_W'(1);
      wp_nxt  = wp_r + AW'(1);
      if (wp_r == AW'(CAPACITY - 1)) begin
        full_nxt = 1'b1;
      end
      if (full_r && (lost_r != '1)) begin
        lost_nxt = lost_r + LOST_W'(1);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req_type == REQ_DUMP) && (retained != '0)) begin
          state_nxt   = ST_DUMP;
          rd_addr_nxt = full_r ? wp_r : '0;
          remain_nxt  = retained;
        end
      end
      ST_DUMP: begin
        if (rd_issue) begin
          rd_addr_nxt = rd_addr_r + AW'(1);
          remain_nxt  = remain_r - CW'(1);
          rd_last_nxt = (remain_r == CW'(1));
          if (remain_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      seq_r        <= '0;
      full_r       <= 1'b0;
      lost_r       <= '0;
      rd_pending_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      seq_r        <= seq_nxt;
      full_r       <= full_nxt;
      lost_r       <= lost_nxt;
      rd_pending_r <= rd_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    remain_r  <= remain_nxt;
    rd_last_r <= rd_last_nxt;
  end

  // retained count as it stands after the push
  assign retained_push = full_nxt ? CW'(CAPACITY) : {1'b0, wp_nxt};

  // pushes never overlap a dump, so reads need no forwarding
  otr_mem #(
    .AW (AW),
    .DW (MW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (wp_r),
    .wr_data ({seq_nxt, in_event_payload[PAYLOAD_WIDTH-1:0]}),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr_r),
    .rd_data (mem_rdata)
  );

  always_comb begin
    ob_wr    = 1'b0;
    ob_wdata = '0;
    if (rd_pending_r) begin
      ob_wr            = 1'b1;
      ob_wdata.kind    = KIND_ENTRY;
      ob_wdata.seq     = mem_rdata[MW-1:PAYLOAD_WIDTH];
      ob_wdata.payload = DATA_W'(mem_rdata[PAYLOAD_WIDTH-1:0]);
      ob_wdata.retained = CNT_W'(retained);
      ob_wdata.lost    = lost_r;
      ob_wdata.last    = rd_last_r;
    end else if (in_acc) begin
      if (in_req_type == REQ_PUSH) begin
        ob_wr             = 1'b1;
        ob_wdata.kind     = KIND_PUSH;
        ob_wdata.seq      = seq_nxt;
        ob_wdata.retained = CNT_W'(retained_push);
        ob_wdata.lost     = lost_nxt;
        ob_wdata.last     = 1'b1;
      end else if (retained == '0) begin
        ob_wr             = 1'b1;
        ob_wdata.kind     = KIND_EMPTY;
        ob_wdata.lost     = lost_r;
        ob_wdata.last     = 1'b1;
      end
    end
  end

  otr_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ob_wr),
    .wr_data (ob_wdata),
    .rd_en   (pop),
    .rd_data (ob_rdata),
    .count   (ob_count)
  );

  assign out_valid             = (ob_count != '0);
  assign out_result_kind       = ob_rdata.kind;
  assign out_sequence_number   = ob_rdata.seq;
  assign out_payload_out       = ob_rdata.payload;
  assign out_retained_count    = ob_rdata.retained;
  assign out_overwritten_count = ob_rdata.lost;
  assign out_last              = ob_rdata.last;

endmodule

>>> src/otr_mem.sv
// Entry store of the trace ring: one write port, one read port, registered read.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module otr_mem #(
  parameter int AW = 6,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/otr_obuf.sv
// Small output queue that decouples result words from the downstream ready.
// Depends on otr_pkg for the result word type and queue depth.
`timescale 1ns / 1ps

module otr_obuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  otr_pkg::result_t              wr_data,
  input  logic                          rd_en,
  output otr_pkg::result_t              rd_data,
  output logic [otr_pkg::OBUF_CW-1:0]   count
);
  import otr_pkg::*;

  result_t              slot_r [OBUF_DEPTH];
  logic [OBUF_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OBUF_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OBUF_CW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + OBUF_AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + OBUF_AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + OBUF_CW'(1);
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - OBUF_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = slot_r[rd_ptr_r];
  assign count   = count_r;

endmodule

>>> test/tb_checker.sv
// Channel monitor for overwrite_trace_ring_top: tracks the ring contents, works out
// the words each accepted request should produce and compares them in order.
// Depends on otr_pkg.
`timescale 1ns / 1ps

module tb_checker #(
  parameter int CAPACITY      = otr_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_WIDTH = otr_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [otr_pkg::DATA_W-1:0]  in_event_payload,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [otr_pkg::KIND_W-1:0]  out_result_kind,
  input  logic [otr_pkg::SEQ_W-1:0]   out_sequence_number,
  input  logic [otr_pkg::DATA_W-1:0]  out_payload_out,
  input  logic [otr_pkg::CNT_W-1:0]   out_retained_count,
  input  logic [otr_pkg::LOST_W-1:0]  out_overwritten_count,
  input  logic                        out_last,
  output int                          fail_count,
  output int                          pending
);
  import otr_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam logic [DATA_W-1:0] PAY_MASK = DATA_W'((64'd1 << PAYLOAD_WIDTH) - 64'd1);

  logic [SEQ_W-1:0]  seq_mem  [CAPACITY];
  logic [DATA_W-1:0] data_mem [CAPACITY];
  logic [PTR_W-1:0]  wr_ptr;
  logic [SEQ_W-1:0]  last_seq;
  logic              ring_full;
  logic [LOST_W-1:0] lost;
  result_t           words_due[$];

  function automatic logic [CNT_W-1:0] held_count();
    return ring_full ? CNT_W'(CAPACITY) : CNT_W'(wr_ptr);
  endfunction

  // Sequence wrap and lost-count saturation are modeled, though a short run
  // never gets near them.
  task automatic ring_take_request(input logic req, input logic [DATA_W-1:0] data);
    result_t          w;
    logic [PTR_W-1:0] slot;
    int               n;
    w = '0;
    if (req == REQ_PUSH) begin
      last_seq = last_seq + 1'b1;
      if (ring_full && lost != '1) lost = lost + 1'b1;
      seq_mem[wr_ptr]  = last_seq;
      data_mem[wr_ptr] = data & PAY_MASK;
      if (wr_ptr == PTR_W'(CAPACITY - 1)) ring_full = 1'b1;
      wr_ptr     = wr_ptr + 1'b1;  // capacity is a power of two
      w.kind     = KIND_PUSH;
      w.seq      = last_seq;
      w.retained = held_count();
      w.lost     = lost;
      w.last     = 1'b1;
      words_due.push_back(w);
    end else begin
      n = held_count();
      if (n == 0) begin
        w.kind = KIND_EMPTY;
        w.lost = lost;
        w.last = 1'b1;
        words_due.push_back(w);
      end else begin
        // oldest entry sits at the write pointer once the ring has wrapped
        slot = ring_full ? wr_ptr : '0;
        for (int i = 0; i < n; i++) begin
          w.kind     = KIND_ENTRY;
          w.seq      = seq_mem[slot];
          w.payload  = data_mem[slot];
          w.retained = CNT_W'(n);
          w.lost     = lost;
          w.last     = (i == n - 1);
          words_due.push_back(w);
          slot = slot + 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin : mon
    result_t w;
    if (!rst_n) begin
      wr_ptr     = '0;
      last_seq   = '0;
      ring_full  = 1'b0;
      lost       = '0;
      fail_count = 0;
      words_due.delete();
    end else begin
      if (in_valid && in_ready) ring_take_request(in_req_type, in_event_payload);
      if (out_valid && out_ready) begin
        if (words_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected word kind %0d seq %h data %h", $realtime,
                     out_result_kind, out_sequence_number, out_payload_out);
          fail_count++;
        end else begin
          w = words_due.pop_front();
          if (out_result_kind !== w.kind || out_sequence_number !== w.seq ||
              out_payload_out !== w.payload || out_retained_count !== w.retained ||
              out_overwritten_count !== w.lost || out_last !== w.last) begin
            if (fail_count < 10) begin
              $display("%0t: word mismatch (exp / got)", $realtime);
              $display("  kind %0d / %0d  seq %h / %h  data %h / %h", w.kind,
                       out_result_kind, w.seq, out_sequence_number, w.payload,
                       out_payload_out);
              $display("  held %0d / %0d  lost %0d / %0d  last %b / %b", w.retained,
                       out_retained_count, w.lost, out_overwritten_count, w.last,
                       out_last);
            end
            fail_count++;
          end
        end
      end
    end
    pending = words_due.size();
  end

endmodule

>>> test/tb_top.sv
// Testbench top for overwrite_trace_ring_top: clock, reset, push/dump stimulus with
// phased idling on both channels, and the verdict. Depends on otr_pkg, the block
// and tb_checker.
`timescale 1ns / 1ps

module tb_top;
  import otr_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_req_type      = 1'b0;
  logic [DATA_W-1:0] in_event_payload = '0;
  logic              out_ready        = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [KIND_W-1:0] out_result_kind;
  logic [SEQ_W-1:0]  out_sequence_number;
  logic [DATA_W-1:0] out_payload_out;
  logic [CNT_W-1:0]  out_retained_count;
  logic [LOST_W-1:0] out_overwritten_count;
  logic              out_last;
  int                fail_count;
  int                pending;

  idle_mode_e idle_mode = IDLE_NONE;
  int         push_total = 0;

  always #2 clk = ~clk;

  overwrite_trace_ring_top #(.CAPACITY(CAP), .PAYLOAD_WIDTH(PAYLOAD_WIDTH_DEF)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_event_payload,
    .out_valid, .out_ready, .out_result_kind, .out_sequence_number, .out_payload_out,
    .out_retained_count, .out_overwritten_count, .out_last
  );

  tb_checker #(.CAPACITY(CAP), .PAYLOAD_WIDTH(PAYLOAD_WIDTH_DEF)) chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_event_payload,
    .out_valid, .out_ready, .out_result_kind, .out_sequence_number, .out_payload_out,
    .out_retained_count, .out_overwritten_count, .out_last, .fail_count, .pending
  );

  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ready = ($urandom_range(99) >= 55);
      IDLE_BOTH:     out_ready = ($urandom_range(99) >= 13);
      default:       out_ready = 1'b1;
    endcase
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 55;
      IDLE_BOTH:   return $urandom_range(99) < 13;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_payload();
    logic [DATA_W-1:0] one_hot;
    one_hot = DATA_W'(1) << $urandom_range(DATA_W - 1);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  // Valid stays up across back-to-back words; it only drops for a gap.
  task automatic send_word(input logic req, input logic [DATA_W-1:0] data);
    while (sender_idles()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_req_type      = req;
    in_event_payload = data;
    do @(posedge clk); while (!in_ready);
    if (req == REQ_PUSH) push_total++;
    @(negedge clk);
  endtask

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic req;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty dump, payload extremes, short dumps, back-to-back dumps
    send_word(REQ_DUMP, 32'h1234_5678);
    send_word(REQ_PUSH, 32'h0000_0000);
    send_word(REQ_PUSH, 32'hFFFF_FFFF);
    send_word(REQ_DUMP, 32'h0000_0000);
    send_word(REQ_PUSH, 32'hAAAA_AAAA);
    send_word(REQ_PUSH, 32'h5555_5555);
    send_word(REQ_DUMP, 32'hFFFF_FFFF);
    send_word(REQ_DUMP, 32'hA5A5_A5A5);
    send_word(REQ_PUSH, 32'h0000_0001);
    send_word(REQ_PUSH, 32'h8000_0000);
    send_word(REQ_DUMP, 32'h0000_0000);

    for (int phase = 0; phase < 5; phase++) begin
      idle_mode = idle_mode_e'(phase % 4);
      for (int k = 0; k < 58; k++) begin
        req = ($urandom_range(99) < 12) ? REQ_DUMP : REQ_PUSH;
        // dump once the ring first fills; push_total then stays put, so all later requests dump
        if (push_total == CAP || push_total == CAP + 1) req = REQ_DUMP;
        send_word(req, pick_payload());
      end
    end
    in_valid  = 1'b0;
    idle_mode = IDLE_NONE;

    wait (pending == 0);
    repeat (3 * CAP) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
